[src/schelling_lattice_move_step_top_macros.svh]
// assertion macros for the schelling lattice move step block
`ifndef SCHELLING_LATTICE_MOVE_STEP_TOP_MACROS_SVH
`define SCHELLING_LATTICE_MOVE_STEP_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SLMS_ASSERT_NOW(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) else $error(msg);
`define SLMS_ASSERT_NEXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) else $error(msg);
`else
`define SLMS_ASSERT_NOW(lbl, ant, con, msg)
`define SLMS_ASSERT_NEXT(lbl, ant, con, msg)
`endif
`endif

[src/slms_pkg.sv]
// shared types and constants for the schelling lattice move step block
`timescale 1ns / 1ps
package slms_pkg;
	localparam int GRID_MAX   = 32;
	localparam int COORD_W    = 5;
	localparam int CELLS      = GRID_MAX * GRID_MAX;
	localparam int CELL_W     = 2 * COORD_W;
	localparam int AGENTS     = 1024;
	localparam int AGENT_W    = 10;
	localparam int OCC_W      = AGENT_W + 1;
	localparam int FEAT_MAX   = 8;
	localparam int FEAT_BITS  = 8;
	localparam int WORD_W     = 64;
	localparam int RADIUS_MAX = 4;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_STEP  = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;
	localparam logic [1:0] KIND_SEAL  = 2'd3;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NO_SLOT  = 2'd1;
	localparam logic [1:0] STAT_BAD      = 2'd2;
	localparam logic [1:0] STAT_OCCUPIED = 2'd3;

	localparam logic [2:0] REG_SIDE    = 3'd0;
	localparam logic [2:0] REG_AGENTS  = 3'd1;
	localparam logic [2:0] REG_FEAT    = 3'd2;
	localparam logic [2:0] REG_RADIUS  = 3'd3;
	localparam logic [2:0] REG_WANTED  = 3'd4;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE,
		S_L0, S_L1, S_L2, S_L3,
		S_S0, S_S1, S_S2,
		S_N0, S_N1, S_N2, S_HAP,
		S_M0, S_M1, S_M2, S_M3,
		S_SH0, S_SH1, S_SH2,
		S_SE1, S_SE2
	} state_t;
endpackage

[src/schelling_lattice_move_step_top.sv]
// schelling lattice move step: sequencer, neighbour scan unit and state memories
//
// channel   direction  handshake               payload
// item      in         start & !busy           kind agent pos_x pos_y culture_word slot
// result    out        done (one cycle)        happy moved neighbour_total neighbour_similar
//                                              new_x new_y status
// config    in         cfg_valid & cfg_ready   cfg_index cfg_data
//
// after reset a clearing pass empties the cell memory; busy is high then.
// busy covers the whole item, with the result strobe in the cycle after its last one.
// load reads the target cell and the agent's old cell; seal visits each lattice cell;
// step and query visit each neighbourhood cell (one memory read port for occupants and
// one for cultures), or stop at a bad agent; a move shifts list entries after the slot.
// one item at a time; results cannot be stalled.
`timescale 1ns / 1ps
`include "schelling_lattice_move_step_top_macros.svh"
module schelling_lattice_move_step_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [9:0]  agent,
	input  logic [4:0]  pos_x,
	input  logic [4:0]  pos_y,
	input  logic [63:0] culture_word,
	input  logic [9:0]  slot,
	output logic        done,
	output logic        happy,
	output logic        moved,
	output logic [6:0]  neighbour_total,
	output logic [6:0]  neighbour_similar,
	output logic [4:0]  new_x,
	output logic [4:0]  new_y,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data
);
	localparam int CW = slms_pkg::CELL_W;
	localparam int AW = slms_pkg::AGENT_W;
	localparam int OW = slms_pkg::OCC_W;
	localparam int XW = slms_pkg::COORD_W;
	localparam int WW = slms_pkg::WORD_W;

	slms_pkg::state_t state_q, state_d;

	// configuration registers
	logic [5:0]  side_q;
	logic [10:0] agents_q;
	logic [3:0]  feat_q;
	logic [2:0]  radius_q;
	logic [16:0] wanted_q;

	// item registers
	logic [1:0]    kind_q;
	logic [AW-1:0] agent_q;
	logic [XW-1:0] px_q, py_q;
	logic [WW-1:0] word_q;
	logic [AW-1:0] slot_q;

	// working registers
	logic [CW-1:0]   loc_q, target_q;
	logic [WW-1:0]   cul_q;
	logic [6:0]      tot_q, sim_q;
	logic signed [3:0] dx_q, dy_q;
	logic [CW-1:0]   j_q, clr_q;
	logic [XW-1:0]   sx_q, sy_q;
	logic [CW:0]     ecount_q;

	// result registers
	logic          done_q, res_happy_q, res_moved_q;
	logic [6:0]    res_tot_q, res_sim_q;
	logic [XW-1:0] res_x_q, res_y_q;
	logic [1:0]    res_stat_q;

	// memory ports
	logic occ_we, loc_we, cul_we, lst_we;
	logic [CW-1:0] occ_waddr, occ_raddr, lst_waddr, lst_raddr, lst_wdata, loc_wdata, loc_rdata;
	logic [CW-1:0] lst_rdata;
	logic [OW-1:0] occ_wdata, occ_rdata;
	logic [AW-1:0] loc_waddr, loc_raddr, cul_waddr, cul_raddr;
	logic [WW-1:0] cul_wdata, cul_rdata;

	slms_ram #(.WIDTH(OW), .DEPTH(slms_pkg::CELLS)) u_occ (
		.clk(clk), .we(occ_we), .waddr(occ_waddr), .wdata(occ_wdata),
		.raddr(occ_raddr), .rdata(occ_rdata));
	slms_ram #(.WIDTH(CW), .DEPTH(slms_pkg::AGENTS)) u_loc (
		.clk(clk), .we(loc_we), .waddr(loc_waddr), .wdata(loc_wdata),
		.raddr(loc_raddr), .rdata(loc_rdata));
	slms_ram #(.WIDTH(WW), .DEPTH(slms_pkg::AGENTS)) u_cul (
		.clk(clk), .we(cul_we), .waddr(cul_waddr), .wdata(cul_wdata),
		.raddr(cul_raddr), .rdata(cul_rdata));
	slms_ram #(.WIDTH(CW), .DEPTH(slms_pkg::CELLS)) u_lst (
		.clk(clk), .we(lst_we), .waddr(lst_waddr), .wdata(lst_wdata),
		.raddr(lst_raddr), .rdata(lst_rdata));

	// effective register values
	logic [5:0]  side_e;
	logic [10:0] agents_e;
	logic [3:0]  feat_e;
	logic [2:0]  radius_e;
	logic [16:0] wanted_e;
	always_comb begin
		side_e   = (side_q == 6'd0) ? 6'd1 :
			(side_q > 6'(slms_pkg::GRID_MAX)) ? 6'(slms_pkg::GRID_MAX) : side_q;
		agents_e = (agents_q == 11'd0) ? 11'd1 :
			(agents_q > 11'(slms_pkg::AGENTS)) ? 11'(slms_pkg::AGENTS) : agents_q;
		feat_e   = (feat_q == 4'd0) ? 4'd1 :
			(feat_q > 4'(slms_pkg::FEAT_MAX)) ? 4'(slms_pkg::FEAT_MAX) : feat_q;
		radius_e = (radius_q == 3'd0) ? 3'd1 :
			(radius_q > 3'(slms_pkg::RADIUS_MAX)) ? 3'(slms_pkg::RADIUS_MAX) : radius_q;
		wanted_e = (wanted_q > 17'd65536) ? 17'd65536 : wanted_q;
	end

	// compared feature mask
	logic [WW-1:0] mask;
	always_comb begin
		for (int k = 0; k < slms_pkg::FEAT_MAX; k++) begin
			mask[k*slms_pkg::FEAT_BITS +: slms_pkg::FEAT_BITS] =
				(4'(k) < feat_e) ? '1 : '0;
		end
	end

	// neighbour coordinate unit
	logic signed [3:0] r_pos, r_neg;
	logic signed [6:0] bx, by;
	logic in_lat, center, last, cell_skip, match;
	always_comb begin
		r_pos = $signed({1'b0, radius_e});
		r_neg = -r_pos;
		bx = $signed({2'b00, loc_q[CW-1:XW]}) + 7'(dx_q);
		by = $signed({2'b00, loc_q[XW-1:0]}) + 7'(dy_q);
		in_lat = (bx >= 0) && (by >= 0) && (bx < $signed({1'b0, side_e}))
			&& (by < $signed({1'b0, side_e}));
		center = (dx_q == 4'sd0) && (dy_q == 4'sd0);
		last = (dx_q == r_pos) && (dy_q == r_pos);
		cell_skip = center || !in_lat;
		match = ((cul_rdata ^ cul_q) & mask) == '0;
	end

	// happiness compare
	logic [23:0] lhs, rhs;
	logic hap;
	always_comb begin
		lhs = {1'b0, sim_q, 16'd0};
		rhs = wanted_e * {17'd0, tot_q};
		hap = (tot_q != 7'd0) && (lhs >= rhs);
	end

	logic [OW-1:0] self_id;
	logic agent_ok, load_ok, slot_ok, target_ok, shift_more, seal_last, seal_ylast, advance;
	always_comb begin
		self_id   = {1'b0, agent_q} + OW'(1);
		agent_ok  = {1'b0, agent_q} < agents_e;
		load_ok   = agent_ok && ({1'b0, px_q} < side_e) && ({1'b0, py_q} < side_e);
		slot_ok   = (ecount_q != '0) && ({1'b0, slot_q} < ecount_q);
		target_ok = (occ_rdata == '0) && ({1'b0, target_q[CW-1:XW]} < side_e)
			&& ({1'b0, target_q[XW-1:0]} < side_e);
		shift_more = ({1'b0, j_q} + (CW+1)'(1)) < ecount_q;
		seal_ylast = {1'b0, sy_q} == (side_e - 6'd1);
		seal_last  = seal_ylast && ({1'b0, sx_q} == (side_e - 6'd1));
	end

	// result of the current item
	logic fin, fin_happy, fin_moved;
	logic [6:0] fin_tot, fin_sim;
	logic [XW-1:0] fin_x, fin_y;
	logic [1:0] fin_stat;

	// next state, memory control and result selection
	always_comb begin
		state_d = state_q;
		advance = 1'b0;
		fin = 1'b0; fin_happy = 1'b0; fin_moved = 1'b0;
		fin_tot = '0; fin_sim = '0; fin_x = '0; fin_y = '0;
		fin_stat = slms_pkg::STAT_OK;
		occ_we = 1'b0; occ_waddr = '0; occ_wdata = '0; occ_raddr = '0;
		loc_we = 1'b0; loc_waddr = '0; loc_wdata = '0; loc_raddr = '0;
		cul_we = 1'b0; cul_waddr = '0; cul_wdata = '0; cul_raddr = '0;
		lst_we = 1'b0; lst_waddr = '0; lst_wdata = '0; lst_raddr = '0;
		case (state_q)
			slms_pkg::S_CLR: begin
				occ_we = 1'b1; occ_waddr = clr_q;
				if (clr_q == CW'(slms_pkg::CELLS - 1)) state_d = slms_pkg::S_IDLE;
			end
			slms_pkg::S_IDLE: begin
				if (start) begin
					case (kind)
						slms_pkg::KIND_LOAD: state_d = slms_pkg::S_L0;
						slms_pkg::KIND_SEAL: state_d = slms_pkg::S_SE1;
						default: state_d = slms_pkg::S_S0;
					endcase
				end
			end
			slms_pkg::S_L0: begin
				occ_raddr = {px_q, py_q}; loc_raddr = agent_q;
				if (!load_ok) begin
					fin = 1'b1; fin_stat = slms_pkg::STAT_BAD;
					fin_x = px_q; fin_y = py_q;
					state_d = slms_pkg::S_IDLE;
				end else begin
					state_d = slms_pkg::S_L1;
				end
			end
			slms_pkg::S_L1: begin
				occ_raddr = loc_rdata;
				fin_x = px_q; fin_y = py_q;
				if (occ_rdata != '0 && occ_rdata != self_id) begin
					fin = 1'b1; fin_stat = slms_pkg::STAT_OCCUPIED;
					state_d = slms_pkg::S_IDLE;
				end else if (occ_rdata == self_id) begin
					cul_we = 1'b1; cul_waddr = agent_q; cul_wdata = word_q;
					fin = 1'b1;
					state_d = slms_pkg::S_IDLE;
				end else begin
					state_d = slms_pkg::S_L2;
				end
			end
			slms_pkg::S_L2: begin
				occ_we = (occ_rdata == self_id); occ_waddr = loc_q;
				cul_we = 1'b1; cul_waddr = agent_q; cul_wdata = word_q;
				state_d = slms_pkg::S_L3;
			end
			slms_pkg::S_L3: begin
				occ_we = 1'b1; occ_waddr = {px_q, py_q}; occ_wdata = self_id;
				loc_we = 1'b1; loc_waddr = agent_q; loc_wdata = {px_q, py_q};
				fin = 1'b1; fin_x = px_q; fin_y = py_q;
				state_d = slms_pkg::S_IDLE;
			end
			slms_pkg::S_S0: begin
				loc_raddr = agent_q; cul_raddr = agent_q;
				if (!agent_ok) begin
					fin = 1'b1; fin_stat = slms_pkg::STAT_BAD;
					state_d = slms_pkg::S_IDLE;
				end else begin
					state_d = slms_pkg::S_S1;
				end
			end
			slms_pkg::S_S1: begin
				occ_raddr = loc_rdata;
				state_d = slms_pkg::S_S2;
			end
			slms_pkg::S_S2: begin
				if (occ_rdata != self_id) begin
					fin = 1'b1; fin_stat = slms_pkg::STAT_BAD;
					state_d = slms_pkg::S_IDLE;
				end else begin
					state_d = slms_pkg::S_N0;
				end
			end
			slms_pkg::S_N0: begin
				occ_raddr = {bx[XW-1:0], by[XW-1:0]};
				if (cell_skip) advance = 1'b1;
				else state_d = slms_pkg::S_N1;
			end
			slms_pkg::S_N1: begin
				cul_raddr = AW'(occ_rdata - OW'(1));
				if (occ_rdata == '0) advance = 1'b1;
				else state_d = slms_pkg::S_N2;
			end
			slms_pkg::S_N2: begin
				advance = 1'b1;
			end
			slms_pkg::S_HAP: begin
				fin_happy = hap; fin_tot = tot_q; fin_sim = sim_q;
				fin_x = loc_q[CW-1:XW]; fin_y = loc_q[XW-1:0];
				if (kind_q == slms_pkg::KIND_STEP && !hap) begin
					state_d = slms_pkg::S_M0;
				end else begin
					fin = 1'b1;
					state_d = slms_pkg::S_IDLE;
				end
			end
			slms_pkg::S_M0: begin
				lst_raddr = slot_q;
				fin_tot = tot_q; fin_sim = sim_q;
				fin_x = loc_q[CW-1:XW]; fin_y = loc_q[XW-1:0];
				if (!slot_ok) begin
					fin = 1'b1; fin_stat = slms_pkg::STAT_NO_SLOT;
					state_d = slms_pkg::S_IDLE;
				end else begin
					state_d = slms_pkg::S_M1;
				end
			end
			slms_pkg::S_M1: begin
				occ_raddr = lst_rdata;
				state_d = slms_pkg::S_M2;
			end
			slms_pkg::S_M2: begin
				fin_tot = tot_q; fin_sim = sim_q;
				fin_x = loc_q[CW-1:XW]; fin_y = loc_q[XW-1:0];
				if (!target_ok) begin
					fin = 1'b1; fin_stat = slms_pkg::STAT_NO_SLOT;
					state_d = slms_pkg::S_IDLE;
				end else begin
					occ_we = 1'b1; occ_waddr = loc_q;
					state_d = slms_pkg::S_M3;
				end
			end
			slms_pkg::S_M3: begin
				occ_we = 1'b1; occ_waddr = target_q; occ_wdata = self_id;
				loc_we = 1'b1; loc_waddr = agent_q; loc_wdata = target_q;
				state_d = slms_pkg::S_SH0;
			end
			slms_pkg::S_SH0: begin
				lst_raddr = j_q + CW'(1);
				state_d = shift_more ? slms_pkg::S_SH1 : slms_pkg::S_SH2;
			end
			slms_pkg::S_SH1: begin
				lst_we = 1'b1; lst_waddr = j_q; lst_wdata = lst_rdata;
				state_d = slms_pkg::S_SH0;
			end
			slms_pkg::S_SH2: begin
				lst_we = 1'b1; lst_waddr = CW'(ecount_q - (CW+1)'(1)); lst_wdata = loc_q;
				fin = 1'b1; fin_moved = 1'b1; fin_tot = tot_q; fin_sim = sim_q;
				fin_x = target_q[CW-1:XW]; fin_y = target_q[XW-1:0];
				state_d = slms_pkg::S_IDLE;
			end
			slms_pkg::S_SE1: begin
				occ_raddr = {sx_q, sy_q};
				state_d = slms_pkg::S_SE2;
			end
			slms_pkg::S_SE2: begin
				lst_we = (occ_rdata == '0); lst_waddr = ecount_q[CW-1:0];
				lst_wdata = {sx_q, sy_q};
				if (seal_last) begin
					fin = 1'b1;
					state_d = slms_pkg::S_IDLE;
				end else begin
					state_d = slms_pkg::S_SE1;
				end
			end
			default: state_d = slms_pkg::S_IDLE;
		endcase
		if (advance) state_d = last ? slms_pkg::S_HAP : slms_pkg::S_N0;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= slms_pkg::S_CLR;
		else state_q <= state_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= 6'd10; agents_q <= 11'd100; feat_q <= 4'd5;
			radius_q <= 3'd1; wanted_q <= 17'd32768;
			ecount_q <= '0; clr_q <= '0; done_q <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_valid) begin
				case (cfg_index)
					slms_pkg::REG_SIDE:   side_q   <= cfg_data[5:0];
					slms_pkg::REG_AGENTS: agents_q <= cfg_data[10:0];
					slms_pkg::REG_FEAT:   feat_q   <= cfg_data[3:0];
					slms_pkg::REG_RADIUS: radius_q <= cfg_data[2:0];
					slms_pkg::REG_WANTED: wanted_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == slms_pkg::S_CLR) clr_q <= clr_q + CW'(1);
			// empty list length
			if (state_q == slms_pkg::S_IDLE && start && kind == slms_pkg::KIND_SEAL)
				ecount_q <= '0;
			if (state_q == slms_pkg::S_SE2 && occ_rdata == '0)
				ecount_q <= ecount_q + (CW+1)'(1);
			done_q <= fin;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == slms_pkg::S_IDLE && start) begin
			kind_q <= kind; agent_q <= agent; px_q <= pos_x; py_q <= pos_y;
			word_q <= culture_word; slot_q <= slot;
			sx_q <= '0; sy_q <= '0;
		end
		if (state_q == slms_pkg::S_L1 || state_q == slms_pkg::S_S1) loc_q <= loc_rdata;
		if (state_q == slms_pkg::S_S1) cul_q <= cul_rdata;
		if (state_q == slms_pkg::S_S2) begin
			dx_q <= r_neg; dy_q <= r_neg; tot_q <= '0; sim_q <= '0;
		end
		if (state_q == slms_pkg::S_N2) begin
			tot_q <= tot_q + 7'd1;
			sim_q <= sim_q + {6'd0, match};
		end
		if (advance) begin
			if (dy_q == r_pos) begin
				dy_q <= r_neg; dx_q <= dx_q + 4'sd1;
			end else begin
				dy_q <= dy_q + 4'sd1;
			end
		end
		if (state_q == slms_pkg::S_M1) target_q <= lst_rdata;
		if (state_q == slms_pkg::S_M3) j_q <= slot_q;
		if (state_q == slms_pkg::S_SH1) j_q <= j_q + CW'(1);
		if (state_q == slms_pkg::S_SE2) begin
			if (seal_ylast) begin
				sy_q <= '0; sx_q <= sx_q + XW'(1);
			end else begin
				sy_q <= sy_q + XW'(1);
			end
		end
		if (fin) begin
			res_happy_q <= fin_happy; res_moved_q <= fin_moved;
			res_tot_q <= fin_tot; res_sim_q <= fin_sim;
			res_x_q <= fin_x; res_y_q <= fin_y; res_stat_q <= fin_stat;
		end
	end

	assign busy = (state_q != slms_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign done = done_q;
	assign happy = res_happy_q;
	assign moved = res_moved_q;
	assign neighbour_total = res_tot_q;
	assign neighbour_similar = res_sim_q;
	assign new_x = res_x_q;
	assign new_y = res_y_q;
	assign status = res_stat_q;

	`SLMS_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "result strobe longer than one cycle")
	`SLMS_ASSERT_NOW(a_done_idle, done_q, !busy, "result shown while still busy")
	`SLMS_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted item did not start work")
	`SLMS_ASSERT_NOW(a_ecount_max, 1'b1, ecount_q <= (CW+1)'(slms_pkg::CELLS),
		"empty list longer than the lattice")
endmodule

[src/slms_ram.sv]
// single write, single registered read port memory
`timescale 1ns / 1ps
module slms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end
endmodule
